// ===== design/ffha_pkg.sv =====
// Shared types and codes for the first-fit heap allocator.
package ffha_pkg;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPL,
    ST_F_RD,
    ST_F_WR,
    ST_M_RD,
    ST_M_CUR,
    ST_M_NXT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [12:0] req_size;
    logic [31:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic        ok;
  } rsp_t;

endpackage

// ===== design/ffha_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator with a header store in RAM.
// Allocate: reads and checks each header in turn from the root, then marks the fit used and may split it.
// Free: address zero needs no RAM access; else frees the header if in range, then merges from the root.
// Init rewrites the root header; unknown requests fail. One item in flight; the output register
// lets a new item be taken while a result waits.
// Reset clears control state and then writes the root header in ST_INIT before going idle.
module first_fit_heap_allocator_unit #(
  parameter int HEAP_WORDS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  ffha_pkg::req_t      req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output ffha_pkg::rsp_t      rsp_o
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int HW = AW + 1;
  localparam int XW = ((AW > 12) ? AW : 12) + 3;

  ffha_pkg::state_e state_q, state_d;

  logic [AW:0]    cur_q, cur_d;
  logic [AW:0]    nxt_q, nxt_d;
  logic [HW-1:0]  cw_q, cw_d;
  logic [11:0]    rw_q, rw_d;
  logic [AW-1:0]  sz_q, sz_d;
  logic [31:0]    res_addr_q, res_addr_d;
  logic           res_ok_q, res_ok_d;
  logic [31:0]    base_q;
  ffha_pkg::rsp_t rsp_q, rsp_d;
  logic           rsp_valid_q, rsp_valid_d;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [HW-1:0]  ram_wdata, ram_rdata;

  logic [AW-1:0]  rd_sz;
  logic           rd_used;
  logic [13:0]    req_rnd;
  logic [31:0]    free_off;
  logic           free_hit;
  logic           cur_end, a_fit, a_split;
  logic [XW-1:0]  a_nxt, m_first, m_sz, m_join, m_skip, m_next;
  logic           m_first_end, merge_ok, m_end, out_free;

  ffha_ram #(
    .WIDTH(HW),
    .DEPTH(HEAP_WORDS)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_sz   = ram_rdata[HW-1:1];
  assign rd_used = ram_rdata[0];

  assign req_rnd  = {1'b0, req_i.req_size} + 14'd3;
  assign free_off = req_i.free_addr - base_q;
  assign free_hit = (free_off[1:0] == 2'b00) && (free_off >= 32'd4) &&
                    (free_off[31:2] <= 30'(HEAP_WORDS));

  assign cur_end = XW'(cur_q) >= XW'(HEAP_WORDS);
  assign a_fit   = !rd_used && (XW'(rd_sz) >= XW'(rw_q));
  assign a_split = XW'(rd_sz) >= (XW'(rw_q) + XW'(2));
  assign a_nxt   = XW'(cur_q) + XW'(1) + XW'(rw_q);

  assign m_first     = XW'(cur_q) + XW'(1) + XW'(rd_sz);
  assign m_first_end = m_first >= XW'(HEAP_WORDS);
  assign merge_ok    = !cw_q[0] && !rd_used;
  assign m_sz        = XW'(cw_q[HW-1:1]) + XW'(1) + XW'(rd_sz);
  assign m_join      = XW'(cur_q) + XW'(1) + m_sz;
  assign m_skip      = XW'(nxt_q) + XW'(1) + XW'(rd_sz);
  assign m_next      = merge_ok ? m_join : m_skip;
  assign m_end       = m_next >= XW'(HEAP_WORDS);

  assign out_free    = !rsp_valid_q || rsp_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::ST_INIT: state_d = ffha_pkg::ST_IDLE;
      ffha_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          case (ffha_pkg::req_type_e'(req_i.req_type))
            ffha_pkg::REQ_ALLOC: state_d = ffha_pkg::ST_A_RD;
            ffha_pkg::REQ_FREE: begin
              if (req_i.free_addr == 32'd0) begin
                state_d = ffha_pkg::ST_FIN;
              end else if (free_hit) begin
                state_d = ffha_pkg::ST_F_RD;
              end else begin
                state_d = ffha_pkg::ST_M_RD;
              end
            end
            default: state_d = ffha_pkg::ST_FIN;
          endcase
        end
      end
      ffha_pkg::ST_A_RD:  state_d = cur_end ? ffha_pkg::ST_FIN : ffha_pkg::ST_A_CHK;
      ffha_pkg::ST_A_CHK: begin
        if (a_fit) begin
          state_d = a_split ? ffha_pkg::ST_A_SPL : ffha_pkg::ST_FIN;
        end else begin
          state_d = ffha_pkg::ST_A_RD;
        end
      end
      ffha_pkg::ST_A_SPL: state_d = ffha_pkg::ST_FIN;
      ffha_pkg::ST_F_RD:  state_d = ffha_pkg::ST_F_WR;
      ffha_pkg::ST_F_WR:  state_d = ffha_pkg::ST_M_RD;
      ffha_pkg::ST_M_RD:  state_d = ffha_pkg::ST_M_CUR;
      ffha_pkg::ST_M_CUR: state_d = m_first_end ? ffha_pkg::ST_FIN : ffha_pkg::ST_M_NXT;
      ffha_pkg::ST_M_NXT: state_d = m_end ? ffha_pkg::ST_FIN : ffha_pkg::ST_M_NXT;
      ffha_pkg::ST_FIN:   state_d = out_free ? ffha_pkg::ST_IDLE : ffha_pkg::ST_FIN;
      default:            state_d = ffha_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    cw_d        = cw_q;
    rw_d        = rw_q;
    sz_d        = sz_q;
    res_addr_d  = res_addr_q;
    res_ok_d    = res_ok_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    case (state_q)
      ffha_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {AW'(HEAP_WORDS - 1), 1'b0};
      end
      ffha_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          cur_d      = '0;
          rw_d       = req_rnd[13:2];
          nxt_d      = (AW+1)'(free_off[31:2] - 30'd1);
          res_addr_d = '0;
          res_ok_d   = 1'b1;
          case (ffha_pkg::req_type_e'(req_i.req_type))
            ffha_pkg::REQ_ALLOC: res_ok_d = 1'b0;
            ffha_pkg::REQ_FREE:  res_ok_d = 1'b1;
            ffha_pkg::REQ_INIT: begin
              ram_we    = 1'b1;
              ram_wdata = {AW'(HEAP_WORDS - 1), 1'b0};
            end
            default: res_ok_d = 1'b0;
          endcase
        end
      end
      ffha_pkg::ST_A_RD: begin
        if (cur_end) begin
          res_addr_d = '0;
          res_ok_d   = 1'b0;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cur_q[AW-1:0];
        end
      end
      ffha_pkg::ST_A_CHK: begin
        if (a_fit) begin
          ram_we     = 1'b1;
          ram_waddr  = cur_q[AW-1:0];
          ram_wdata  = {(a_split ? AW'(rw_q) : rd_sz), 1'b1};
          res_addr_d = base_q + ((32'(cur_q) + 32'd1) << 2);
          res_ok_d   = 1'b1;
          nxt_d      = (AW+1)'(a_nxt);
          sz_d       = AW'(XW'(rd_sz) - XW'(rw_q) - XW'(1));
        end else begin
          cur_d = (AW+1)'(m_first);
        end
      end
      ffha_pkg::ST_A_SPL: begin
        if (XW'(nxt_q) < XW'(HEAP_WORDS)) begin
          ram_we    = 1'b1;
          ram_waddr = nxt_q[AW-1:0];
          ram_wdata = {sz_q, 1'b0};
        end
      end
      ffha_pkg::ST_F_RD: begin
        ram_re    = 1'b1;
        ram_raddr = nxt_q[AW-1:0];
      end
      ffha_pkg::ST_F_WR: begin
        ram_we    = 1'b1;
        ram_waddr = nxt_q[AW-1:0];
        ram_wdata = {rd_sz, 1'b0};
        cur_d     = '0;
      end
      ffha_pkg::ST_M_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_q[AW-1:0];
      end
      ffha_pkg::ST_M_CUR: begin
        cw_d = ram_rdata;
        if (!m_first_end) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(m_first);
          nxt_d     = (AW+1)'(m_first);
        end
      end
      ffha_pkg::ST_M_NXT: begin
        if (merge_ok) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q[AW-1:0];
          ram_wdata = {AW'(m_sz), 1'b0};
          cw_d      = {AW'(m_sz), 1'b0};
        end else begin
          cur_d = nxt_q;
          cw_d  = ram_rdata;
        end
        if (!m_end) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(m_next);
          nxt_d     = (AW+1)'(m_next);
        end
      end
      ffha_pkg::ST_FIN: begin
        if (out_free) begin
          rsp_valid_d       = 1'b1;
          rsp_d.result_addr = res_addr_q;
          rsp_d.ok          = res_ok_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::ST_INIT;
      rsp_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    cw_q       <= cw_d;
    rw_q       <= rw_d;
    sz_q       <= sz_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    rsp_q      <= rsp_d;
  end

  assign req_ready_o = (state_q == ffha_pkg::ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== design/ffha_checker.sv =====
// Port-level checks for the first-fit heap allocator, bound to the top level.
module ffha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input ffha_pkg::rsp_t rsp_o
);

  logic [1:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = req_valid_i && req_ready_o;
  assign out_acc = rsp_valid_o && rsp_ready_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.ok |-> rsp_o.result_addr == 32'd0)
    else $error("failed item carries an address");

  a_root_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !req_ready_o)
    else $error("item taken before root header written");

  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc |-> cnt_q < 2'd2) and (rsp_valid_o |-> cnt_q != 2'd0))
    else $error("item count out of range");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_valid_i),
  .req_ready_o(req_ready_o),
  .rsp_valid_o(rsp_valid_o),
  .rsp_ready_i(rsp_ready_i),
  .rsp_o      (rsp_o)
);
